>>> design/lds_pkg.sv
// Package for the linear Diophantine solver: widths, codes, sequencer states.
package lds_pkg;
	localparam int unsigned LDS_WIDTH = 32;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZERO   = 2'd1,
		ST_NOSOL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EUC_DIV,
		S_EUC_UPD,
		S_CHK_DIV,
		S_K_DIV,
		S_V_MUL,
		S_V_DIV,
		S_X_MUL,
		S_Y_MUL,
		S_XS_DIV,
		S_YS_DIV,
		S_OUT
	} state_t;
endpackage

>>> design/lds_div.sv
// Shared restoring divider on magnitudes, one quotient bit per cycle.
module lds_div import lds_pkg::*; #(
	parameter int unsigned N = 66
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] num,
	input  logic [N-1:0] den,
	output logic         done,
	output logic [N-1:0] quo,
	output logic [N-1:0] rem
);
	localparam int unsigned CW = $clog2(N + 1);
	logic [N-1:0] q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [N:0] trial;

	assign trial = {r_q, q_q[N-1]} - {1'b0, d_q};
	assign quo = q_q;
	assign rem = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[N]) begin
				r_q <= trial[N-1:0];
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= {r_q[N-2:0], q_q[N-1]};
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end
endmodule

>>> design/linear_diophantine_solver_unit.sv
// Top level of the linear Diophantine solver: sequencer around one shared divider.
// Sequence: each divider pass runs start, the quotient bits, then done, plus an
//   update state per Euclid step; up to ~46 Euclid steps plus five more divisions;
//   inputs with both coefficients zero go straight to the result.
// Throughput: one item at a time; s_tready is low from accept until the
//   result beat is taken; the divider's bit-serial loop takes most of each item.
// Reset: arst_n clears the sequencer and the output valid; no memories.
module linear_diophantine_solver_unit import lds_pkg::*; #(
	parameter int unsigned WIDTH = LDS_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // coef_a[31:0], coef_b[63:32], rhs_c[95:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata   // status[1:0], x_base[33:2], y_base[65:34],
	                               // x_step[97:66], y_step[129:98], overflow[130], zero
);
	// Internal math runs 66 bits wide: Bezout values stay within 2^32,
	// products of those with |k| <= 2^31 fit in 65 bits signed.
	localparam int unsigned N = 66;
	localparam logic signed [N-1:0] WMAX = (N'(1) <<< (WIDTH - 1)) - N'(1);
	localparam logic signed [N-1:0] WMIN = -(N'(1) <<< (WIDTH - 1));

	state_t st_q, st_nx;
	logic signed [N-1:0] a_q, b_q, c_q, aa_q, bb_q;
	logic signed [N-1:0] r_q, pr_q, s_q, ps_q, q_q, d_q, k_q, u_q, v_q, t_q;
	logic signed [N-1:0] x0_q, y0_q, xs_q, ys_q;
	logic [1:0] stat_q;
	logic ovf_q;
	logic out_v_q;

	// shared divider, operand signs handled here (C truncation semantics)
	logic dv_start, dv_done;
	logic signed [N-1:0] dv_n, dv_d;
	logic [N-1:0] dv_qm, dv_rm;
	logic signed [N-1:0] dv_q, dv_r;
	logic dv_nneg, dv_dneg;

	assign dv_nneg = dv_n[N-1];
	assign dv_dneg = dv_d[N-1];

	lds_div #(.N(N)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(dv_nneg ? -dv_n : dv_n), .den(dv_dneg ? -dv_d : dv_d),
		.done(dv_done), .quo(dv_qm), .rem(dv_rm)
	);
	assign dv_q = (dv_nneg ^ dv_dneg) ? -$signed(dv_qm) : $signed(dv_qm);
	assign dv_r = dv_nneg ? -$signed(dv_rm) : $signed(dv_rm);

	// one shared multiplier: every operand magnitude is at most 2^31,
	// so a 32x32 unsigned core on magnitudes covers all uses
	logic signed [N-1:0] mul_a, mul_b, mul_p;
	logic [31:0] mul_am, mul_bm;
	logic [63:0] mul_pm;
	assign mul_am = mul_a[N-1] ? 32'(-mul_a) : mul_a[31:0];
	assign mul_bm = mul_b[N-1] ? 32'(-mul_b) : mul_b[31:0];
	assign mul_pm = mul_am * mul_bm;
	assign mul_p = (mul_a[N-1] ^ mul_b[N-1]) ? -$signed({2'b00, mul_pm}) :
		$signed({2'b00, mul_pm});

	logic dv_busy_q;
	assign dv_start = !dv_busy_q && (st_q == S_EUC_DIV || st_q == S_CHK_DIV ||
		st_q == S_K_DIV || st_q == S_V_DIV || st_q == S_XS_DIV ||
		st_q == S_YS_DIV);

	always_comb begin
		dv_n = pr_q;
		dv_d = r_q;
		case (st_q)
			S_CHK_DIV: begin dv_n = c_q; dv_d = pr_q; end
			S_K_DIV:   begin dv_n = c_q; dv_d = d_q; end
			S_V_DIV:   begin dv_n = t_q; dv_d = bb_q; end
			S_XS_DIV:  begin dv_n = b_q; dv_d = d_q; end
			S_YS_DIV:  begin dv_n = a_q; dv_d = d_q; end
			default:   begin dv_n = pr_q; dv_d = r_q; end
		endcase
	end

	always_comb begin
		mul_a = q_q;
		mul_b = s_q;
		case (st_q)
			S_V_MUL: begin mul_a = ps_q; mul_b = aa_q; end
			S_X_MUL: begin mul_a = u_q;  mul_b = k_q;  end
			S_Y_MUL: begin mul_a = v_q;  mul_b = k_q;  end
			default: begin mul_a = q_q;  mul_b = s_q;  end
		endcase
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			S_IDLE:    if (s_tvalid) st_nx = S_EUC_UPD;
			S_EUC_UPD: st_nx = (r_q == '0) ? S_CHK_DIV : S_EUC_DIV;
			S_EUC_DIV: if (dv_done) st_nx = S_EUC_UPD;
			S_CHK_DIV: if (dv_done) st_nx = S_K_DIV;
			S_K_DIV:   if (dv_done) st_nx = S_V_MUL;
			S_V_MUL:   st_nx = S_V_DIV;
			S_V_DIV:   if (dv_done) st_nx = S_X_MUL;
			S_X_MUL:   st_nx = S_Y_MUL;
			S_Y_MUL:   st_nx = S_XS_DIV;
			S_XS_DIV:  if (dv_done) st_nx = S_YS_DIV;
			S_YS_DIV:  if (dv_done) st_nx = S_OUT;
			S_OUT:     if (!out_v_q) st_nx = S_IDLE;
			default:   st_nx = S_IDLE;
		endcase
		if (st_q == S_IDLE && s_tvalid &&
		    s_tdata[31:0] == '0 && s_tdata[63:32] == '0)
			st_nx = S_OUT;
		if (st_q == S_CHK_DIV && dv_done && dv_r != '0) st_nx = S_OUT;
		if (st_q == S_V_DIV && dv_done && bb_q == '0) st_nx = S_X_MUL;
		if (st_q == S_V_MUL && bb_q == '0) st_nx = S_X_MUL;
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (st_q == S_IDLE) && !out_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_v_q <= 1'b0;
			dv_busy_q <= 1'b0;
		end else begin
			if (st_q == S_IDLE && out_v_q) st_q <= S_IDLE;
			else st_q <= st_nx;
			if (dv_start) dv_busy_q <= 1'b1;
			else if (dv_done) dv_busy_q <= 1'b0;
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			else if (st_q == S_OUT && !out_v_q) out_v_q <= 1'b1;
		end
	end

	function automatic logic signed [N-1:0] sx(input logic [31:0] v);
		sx = N'($signed(v));
	endfunction

	function automatic logic signed [N-1:0] wrapw(input logic signed [N-1:0] v);
		logic signed [N-1:0] m;
		m = (N'(1) <<< WIDTH) - N'(1);
		wrapw = v;
		if (WIDTH < 64) begin
			wrapw = v & m;
			if (wrapw[WIDTH-1]) wrapw = wrapw - (N'(1) <<< WIDTH);
		end
	endfunction

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (s_tvalid && s_tready) begin
				a_q <= sx(s_tdata[31:0]);
				b_q <= sx(s_tdata[63:32]);
				c_q <= sx(s_tdata[95:64]);
				aa_q <= s_tdata[31] ? -sx(s_tdata[31:0]) : sx(s_tdata[31:0]);
				bb_q <= s_tdata[63] ? -sx(s_tdata[63:32]) : sx(s_tdata[63:32]);
				pr_q <= s_tdata[31] ? -sx(s_tdata[31:0]) : sx(s_tdata[31:0]);
				r_q  <= s_tdata[63] ? -sx(s_tdata[63:32]) : sx(s_tdata[63:32]);
				// seeded so the first update pass lands on ps=1, s=0
				s_q <= N'(1);
				ps_q <= '0;
				q_q <= '0;
				stat_q <= (s_tdata[63:0] == '0) ? ST_ZERO : ST_OK;
				ovf_q <= 1'b0;
				x0_q <= '0; y0_q <= '0; xs_q <= '0; ys_q <= '0;
			end
			S_EUC_DIV: if (dv_done) q_q <= dv_q;
			S_EUC_UPD: begin
				// apply the quotient from the previous division
				ps_q <= s_q;
				s_q  <= ps_q - mul_p;
			end
			S_CHK_DIV: begin
				d_q <= pr_q;
				if (dv_done && dv_r != '0) stat_q <= ST_NOSOL;
			end
			S_K_DIV: if (dv_done) begin
				k_q <= dv_q;
				u_q <= ps_q;
			end
			S_V_MUL: begin
				t_q <= pr_q - mul_p;
				v_q <= '0;
			end
			S_V_DIV: if (dv_done) v_q <= dv_q;
			S_X_MUL: x0_q <= a_q[N-1] ? -mul_p : mul_p;
			S_Y_MUL: y0_q <= b_q[N-1] ? -mul_p : mul_p;
			S_XS_DIV: begin
				if (x0_q > WMAX || x0_q < WMIN || y0_q > WMAX || y0_q < WMIN)
					ovf_q <= 1'b1;
				if (dv_done) xs_q <= dv_q;
			end
			S_YS_DIV: if (dv_done) ys_q <= -dv_q;
			default: ;
		endcase
		// Euclid remainders move on the cycle the division finishes
		if (st_q == S_EUC_DIV && dv_done) begin
			pr_q <= r_q;
			r_q  <= dv_r;
		end
	end

	logic signed [N-1:0] xw, yw;
	assign xw = wrapw(x0_q);
	assign yw = wrapw(y0_q);

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'd0, ovf_q, ys_q[31:0], xs_q[31:0], yw[31:0], xw[31:0], stat_q};

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_tready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && stat_q != ST_OK) |-> (xs_q == '0 && ovf_q == 1'b0))
		else $error("error result not cleared");
endmodule
